// ----- sv/tcpr_pkg.sv -----
package tcpr_pkg;

   // Font store geometry
   localparam int MAX_GLYPH_HEIGHT = 32;
   localparam int CHAR_COUNT       = 256;
   localparam int STORE_DEPTH      = CHAR_COUNT * MAX_GLYPH_HEIGHT;
   localparam int ADDR_W           = $clog2(STORE_DEPTH);
   localparam int WORD_W           = 32;

   // code (8 bits) * height (6 bits) + line (5 bits) always fits in 14 bits
   localparam int SUM_W            = 14;

   // Render queue between front and back
   localparam int QDEPTH           = 4;
   localparam int QPTR_W           = $clog2(QDEPTH);
   localparam int QCNT_W           = $clog2(QDEPTH + 1);

   localparam int MAX_PIXELS       = 32;
   localparam logic [5:0] WIDTH_9BIT = 6'd9;

   // Commands
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   // Register indexes
   localparam logic REG_GLYPH_WIDTH  = 1'b0;
   localparam logic REG_GLYPH_HEIGHT = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] row;
      logic [3:0]        fg;
      logic [3:0]        bg;
   } render_type;

endpackage

// ----- sv/tcpr_ram.sv -----
module tcpr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tcpr_front.sv -----
module tcpr_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [15:0]                    req_cell_value,
   input  logic [4:0]                     req_line_number,
   input  logic [31:0]                    req_font_word,
   input  logic [5:0]                     glyph_width,
   input  logic [5:0]                     glyph_height,
   input  logic [tcpr_pkg::QCNT_W-1:0]    queue_count,
   output logic                           queue_push,
   output tcpr_pkg::render_type           queue_entry,
   output logic                           ram_wr_en,
   output logic [tcpr_pkg::ADDR_W-1:0]    ram_wr_addr,
   output logic [tcpr_pkg::WORD_W-1:0]    ram_wr_data,
   output logic                           ram_rd_en,
   output logic [tcpr_pkg::ADDR_W-1:0]    ram_rd_addr,
   input  logic [tcpr_pkg::WORD_W-1:0]    ram_rd_data
);
   import tcpr_pkg::*;

   logic             accept;
   logic [SUM_W-1:0] addr_sum;
   logic [ADDR_W-1:0] addr;
   logic             pend_valid_ff, pend_valid_in;
   logic [3:0]       pend_fg_ff, pend_bg_ff;

   // Room is counted including the read still in flight
   assign req_ready = ({1'b0, queue_count} + {{QCNT_W{1'b0}}, pend_valid_ff})
                      < (QCNT_W + 1)'(QDEPTH);
   assign accept = req_valid && req_ready;

   // Store address wraps at the store depth
   assign addr_sum = SUM_W'(req_cell_value[7:0]) * SUM_W'(glyph_height)
                     + SUM_W'(req_line_number);
   assign addr     = addr_sum[ADDR_W-1:0];

   assign ram_wr_en   = accept && (req_command == CMD_WRITE);
   assign ram_wr_addr = addr;
   assign ram_wr_data = req_font_word;

   // Zero-width renders produce nothing and are dropped here
   assign ram_rd_en   = accept && (req_command == CMD_RENDER) && (glyph_width != 6'd0);
   assign ram_rd_addr = addr;

   assign pend_valid_in = ram_rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      if (ram_rd_en) begin
         pend_fg_ff <= req_cell_value[11:8];
         pend_bg_ff <= req_cell_value[15:12];
      end
   end

   assign queue_push     = pend_valid_ff;
   assign queue_entry.row = ram_rd_data;
   assign queue_entry.fg  = pend_fg_ff;
   assign queue_entry.bg  = pend_bg_ff;

endmodule

// ----- sv/tcpr_queue.sv -----
module tcpr_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tcpr_pkg::render_type        push_entry,
   input  logic                        pop,
   output tcpr_pkg::render_type        head_entry,
   output logic                        empty,
   output logic [tcpr_pkg::QCNT_W-1:0] count
);
   import tcpr_pkg::*;

   render_type        slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = slot_ff[rd_ptr_ff];
   assign empty      = (count_ff == '0);
   assign count      = count_ff;

endmodule

// ----- sv/tcpr_back.sv -----
module tcpr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [5:0]           glyph_width,
   input  logic                 queue_empty,
   input  tcpr_pkg::render_type queue_head,
   output logic                 queue_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_pixel_color,
   output logic [4:0]           rsp_pixel_column,
   output logic                 rsp_last_pixel
);
   import tcpr_pkg::*;

   logic       active_ff, active_in;
   logic [4:0] col_ff, col_in;
   render_type cur_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] color_ff;
   logic [4:0] column_ff;
   logic       last_ff;

   logic [5:0] w_eff;
   logic [4:0] top;
   logic [4:0] bit_idx;
   logic       emit;
   logic       is_last;
   logic       repeat_col;
   logic [3:0] color;

   always_comb begin
      w_eff = (glyph_width > 6'(MAX_PIXELS)) ? 6'(MAX_PIXELS) : glyph_width;
      if (w_eff > 6'd16) begin
         top = 5'd31;
      end else if (w_eff > WIDTH_9BIT) begin
         top = 5'd15;
      end else begin
         top = 5'd7;
      end
      bit_idx    = top - col_ff;
      emit       = active_ff && (!rsp_valid_ff || rsp_ready);
      is_last    = ({1'b0, col_ff} + 6'd1) == w_eff;
      queue_pop  = !queue_empty && (!active_ff || (emit && is_last));
      // Nine-wide cells repeat the previous pixel from column 8 on
      repeat_col = (w_eff == WIDTH_9BIT) && (col_ff >= 5'd8);
      if (repeat_col) begin
         color = color_ff;
      end else begin
         color = cur_ff.row[bit_idx] ? cur_ff.fg : cur_ff.bg;
      end

      if (queue_pop) begin
         active_in = 1'b1;
         col_in    = '0;
      end else if (emit) begin
         active_in = !is_last;
         col_in    = col_ff + 5'd1;
      end else begin
         active_in = active_ff;
         col_in    = col_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (queue_pop) begin
         cur_ff <= queue_head;
      end
      if (emit) begin
         color_ff  <= color;
         column_ff <= col_ff;
         last_ff   <= is_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_color  = color_ff;
   assign rsp_pixel_column = column_ff;
   assign rsp_last_pixel   = last_ff;

endmodule

// ----- sv/text_cell_pixel_renderer.sv -----
// Channel   Ports                                         Direction
// --------  --------------------------------------------  ---------
// req       req_valid/req_ready, command, cell, line, word  in
// rsp       rsp_valid/rsp_ready, color, column, last        out
// csr       csr_write_enable, csr_index, csr_write_data     in
//
// A render sends one pixel per glyph column (none at width 0, at most 32),
// one pixel per cycle out of the back end's column counter while rsp does not stall.
// Front accepts one item per cycle while the 4-entry render queue has room;
// rsp_valid for a first pixel follows the store read, queue, active flag and output reg.
// Reset clears control state only; the font store is not cleared.
// rsp stalls hold the back end; the front keeps filling the queue meanwhile.
module text_cell_pixel_renderer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_cell_value,
   input  logic [4:0]  req_line_number,
   input  logic [31:0] req_font_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_pixel_color,
   output logic [4:0]  rsp_pixel_column,
   output logic        rsp_last_pixel,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [5:0]  csr_write_data
);
   import tcpr_pkg::*;

   // Config registers
   logic [5:0] glyph_width_ff, glyph_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff  <= 6'd8;
         glyph_height_ff <= 6'd16;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_GLYPH_WIDTH: begin
               glyph_width_ff <= csr_write_data;
            end
            REG_GLYPH_HEIGHT: begin
               glyph_height_ff <= csr_write_data;
            end
         endcase
      end
   end

   // Font store
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

   tcpr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_font_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Front: decode, address, store writes and row reads
   logic              queue_push, queue_pop, queue_empty;
   render_type        queue_entry, queue_head;
   logic [QCNT_W-1:0] queue_count;

   tcpr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_cell_value  (req_cell_value),
      .req_line_number (req_line_number),
      .req_font_word   (req_font_word),
      .glyph_width     (glyph_width_ff),
      .glyph_height    (glyph_height_ff),
      .queue_count     (queue_count),
      .queue_push      (queue_push),
      .queue_entry     (queue_entry),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   // Render queue: row word plus colors per pending cell line
   tcpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .pop        (queue_pop),
      .head_entry (queue_head),
      .empty      (queue_empty),
      .count      (queue_count)
   );

   // Back: pixel serializer with output register
   tcpr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .glyph_width      (glyph_width_ff),
      .queue_empty      (queue_empty),
      .queue_head       (queue_head),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

// Bench for the text cell pixel renderer.
// Font writes and render commands go in on req_*, pixels come back on rsp_*.
// An in-bench copy of the font store and of both glyph registers predicts every
// pixel at the moment its render is accepted. The predicted pixels sit in a FIFO,
// and each rsp transfer is checked against the oldest one.
module tb;
   import tcpr_pkg::*;

   typedef struct {
      logic [3:0] color;
      logic [4:0] column;
      logic       last;
   } pixel_type;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;    // font writes leave no trace on rsp; let them land
   localparam int TAIL_CYCLES   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_WRITE;
   logic [15:0] req_cell_value = '0;
   logic [4:0]  req_line_number = '0;
   logic [31:0] req_font_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_pixel_color;
   logic [4:0]  rsp_pixel_column;
   logic        rsp_last_pixel;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = REG_GLYPH_WIDTH;
   logic [5:0]  csr_write_data = '0;

   // Bench copy of the block state
   logic [31:0] font_mem [STORE_DEPTH];
   bit          font_seen [STORE_DEPTH];   // never render an entry that was not written
   logic [5:0]  cur_width = 6'd8;
   logic [5:0]  cur_height = 6'd16;

   pixel_type   pixel_q[$];               // pixels still owed by the block
   int          err_count = 0;
   int          cycle_count = 0;
   bit          idle_on = 1'b1;           // random idling on both channels
   int          hold_cycles = 0;          // receiver hold-off, counted down below

   text_cell_pixel_renderer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_cell_value   (req_cell_value),
      .req_line_number  (req_line_number),
      .req_font_word    (req_font_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: the run should never get near this. On expiry, fail and stop.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Font store address: char code times height plus line, wrapped to store depth.
   // A line at or past the height reaches into the next character's rows.
   function automatic int font_addr(logic [7:0] code, logic [4:0] line);
      return (int'(code) * int'(cur_height) + int'(line)) % STORE_DEPTH;
   endfunction

   // Runs at every req transfer. A write updates the bench font copy. A render
   // queues the pixels the block owes.
   function automatic void apply_req(logic cmd, logic [15:0] cell_val, logic [4:0] line,
                                     logic [31:0] word);
      int         a;
      int         w;
      int         top;
      logic [31:0] row;
      logic [3:0] color;
      logic [3:0] prev;
      pixel_type  px;
      a = font_addr(cell_val[7:0], line);
      if (cmd == CMD_WRITE) begin
         font_mem[a] = word;          // all 32 bits stored, whatever the width
         font_seen[a] = 1'b1;
         return;
      end
      // widths above 32 saturate; zero width draws nothing
      w = (cur_width > 6'd32) ? 32 : int'(cur_width);
      // row word size: 1 byte up to 9, 2 bytes up to 16, else 4; MSB is leftmost
      top = (w > 16) ? 31 : ((w > 9) ? 15 : 7);
      row = font_mem[a];
      prev = '0;
      for (int lx = 0; lx < w; lx++) begin
         if (w == 9 && lx >= 8)
            color = prev;             // 9-wide: column 8 repeats column 7
         else
            color = row[top - lx] ? cell_val[11:8] : cell_val[15:12];
         prev = color;
         px.color = color;
         px.column = 5'(lx);
         px.last = (lx == w - 1);
         pixel_q.push_back(px);
      end
   endfunction

   // One req transfer. Valid may drop only for random idle cycles, and it stays
   // high back to back when there is no idling.
   task automatic send_req(input logic cmd, input logic [15:0] cell_val,
                           input logic [4:0] line, input logic [31:0] word);
      while (idle_on && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_cell_value  <= cell_val;
      req_line_number <= line;
      req_font_word   <= word;
      do @(posedge clock); while (!req_ready);
      apply_req(cmd, cell_val, line, word);
   endtask

   // Register write. It happens only with the block idle: all pixels are back,
   // and enough cycles have passed for any trailing font write to settle.
   task automatic set_config(input logic idx, input logic [5:0] val);
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_GLYPH_WIDTH)
         cur_width = val;
      else
         cur_height = val;
   endtask

   // One random command. A render targets a written entry. When the chosen
   // entry is unwritten, a font write to it goes first (sent returns 2).
   task automatic send_random_item(output int sent);
      logic [7:0]  code;
      logic [4:0]  line;
      logic [15:0] cell_val;
      logic [15:0] wcell;
      // half the codes come from a small pool, so renders reuse stored rows
      if ($urandom_range(0, 1))
         code = 8'($urandom_range(0, 255));
      else
         code = 8'($urandom_range(8'h40, 8'h47));
      line = 5'($urandom_range(0, 31));
      cell_val = 16'($urandom);
      cell_val[7:0] = code;
      wcell = 16'($urandom);
      wcell[7:0] = code;
      sent = 1;
      if ($urandom_range(0, 99) < 30) begin
         send_req(CMD_WRITE, wcell, line, $urandom);
      end else begin
         if (!font_seen[font_addr(code, line)]) begin
            send_req(CMD_WRITE, wcell, line, $urandom);
            sent = 2;
         end
         send_req(CMD_RENDER, cell_val, line, $urandom);
      end
   endtask

   function automatic logic [5:0] pick_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return 6'd9;
      if (r < 30) begin
         case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd16;
            3: return 6'd17;
            4: return 6'd32;
            default: return 6'd63;
         endcase
      end
      return 6'($urandom_range(1, 20));   // mostly narrow glyphs, keeps the run short
   endfunction

   // Directed: field extremes, both commands, every row word size, the 9-wide
   // repeat, saturation, zero width, and address aliasing and wrap.
   task automatic test_directed;
      send_req(CMD_WRITE, 16'h0000, 5'd0, 32'hFFFF_FFFF);
      send_req(CMD_WRITE, 16'hFFFF, 5'd31, 32'h0000_0000);   // line past height
      send_req(CMD_WRITE, 16'h0041, 5'd5, 32'h0000_0080);    // leftmost pixel only
      send_req(CMD_RENDER, 16'hA500, 5'd0, 32'h0000_0000);
      send_req(CMD_RENDER, 16'h0000, 5'd0, 32'hFFFF_FFFF);   // word ignored on render
      send_req(CMD_RENDER, 16'hFFFF, 5'd31, 32'h0000_0000);
      send_req(CMD_RENDER, 16'h3C41, 5'd5, 32'h0000_0000);

      set_config(REG_GLYPH_WIDTH, 6'd9);
      send_req(CMD_WRITE, 16'h0042, 5'd1, 32'h0000_0001);    // column 7 set, 8 repeats it
      send_req(CMD_RENDER, 16'h3C42, 5'd1, 32'h0000_0000);
      send_req(CMD_RENDER, 16'h3C41, 5'd5, 32'h0000_0000);

      set_config(REG_GLYPH_WIDTH, 6'd16);
      send_req(CMD_WRITE, 16'h0043, 5'd2, 32'h0000_8001);
      send_req(CMD_RENDER, 16'h7943, 5'd2, 32'h0000_0000);
      set_config(REG_GLYPH_WIDTH, 6'd17);                    // switches to 4-byte rows
      send_req(CMD_RENDER, 16'h7943, 5'd2, 32'h0000_0000);

      set_config(REG_GLYPH_WIDTH, 6'd32);
      send_req(CMD_WRITE, 16'h0044, 5'd3, 32'h8000_0001);
      send_req(CMD_RENDER, 16'h2D44, 5'd3, 32'h0000_0000);
      set_config(REG_GLYPH_WIDTH, 6'd63);                    // saturates at 32
      send_req(CMD_RENDER, 16'h2D44, 5'd3, 32'h0000_0000);
      set_config(REG_GLYPH_WIDTH, 6'd0);                     // no pixels at all
      send_req(CMD_RENDER, 16'hD244, 5'd3, 32'h0000_0000);
      set_config(REG_GLYPH_WIDTH, 6'd1);
      send_req(CMD_RENDER, 16'h2D44, 5'd3, 32'h0000_0000);

      // height 0: every char shares the rows, code 0x99 and 0x12 alias
      set_config(REG_GLYPH_HEIGHT, 6'd0);
      send_req(CMD_WRITE, 16'h0099, 5'd7, 32'h0000_0080);
      send_req(CMD_RENDER, 16'h6512, 5'd7, 32'h0000_0000);
      // height 63: the top addresses wrap around the store
      set_config(REG_GLYPH_HEIGHT, 6'd63);
      send_req(CMD_WRITE, 16'h00FF, 5'd31, 32'h5555_5555);
      send_req(CMD_RENDER, 16'h8CFF, 5'd31, 32'h0000_0000);
   endtask

   // Random phases. The first ones pin width/height pairs at the extremes, the
   // rest draw them at random.
   task automatic test_random_phases;
      int sent;
      int n;
      logic [5:0] w;
      logic [5:0] h;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin w = 6'd9;  h = 6'd16; end
            1: begin w = 6'd1;  h = 6'd63; end
            2: begin w = 6'd32; h = 6'd1;  end
            3: begin w = 6'd63; h = 6'd0;  end
            4: begin w = 6'd16; h = 6'd32; end
            5: begin w = 6'd17; h = 6'd5;  end
            default: begin
               w = pick_width();
               h = 6'($urandom_range(0, 63));
            end
         endcase
         set_config(REG_GLYPH_WIDTH, w);
         set_config(REG_GLYPH_HEIGHT, h);
         n = 0;
         while (n < 42) begin
            send_random_item(sent);
            n += sent;
         end
      end
   endtask

   // No idling on either side, at the standard 9-wide rate
   task automatic test_no_idle;
      int sent;
      int n;
      set_config(REG_GLYPH_WIDTH, 6'd9);
      idle_on = 1'b0;
      n = 0;
      while (n < 60) begin
         send_random_item(sent);
         n += sent;
      end
      idle_on = 1'b1;
   endtask

   // Receiver holds off for a long stretch while renders keep coming. The
   // render queue fills and req_ready must drop, with no pixel lost.
   task automatic test_backpressure;
      int sent;
      int n;
      set_config(REG_GLYPH_WIDTH, 6'd32);
      idle_on = 1'b0;
      hold_cycles = 300;
      n = 0;
      while (n < 30) begin
         send_random_item(sent);
         n += sent;
      end
      idle_on = 1'b1;
   endtask

   // Receiver: hold-off first, then random idling
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(0, 99) < 28);
         end
      end
   end

   // Check each rsp transfer against the oldest predicted pixel
   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_q.size() == 0) begin
            $error("pixel transfer with nothing expected: color %0d column %0d last %0d",
                   rsp_pixel_color, rsp_pixel_column, rsp_last_pixel);
            err_count++;
         end else begin
            exp_px = pixel_q.pop_front();
            if (rsp_pixel_color !== exp_px.color) begin
               $error("pixel_color: expected %0d, actual %0d", exp_px.color, rsp_pixel_color);
               err_count++;
            end
            if (rsp_pixel_column !== exp_px.column) begin
               $error("pixel_column: expected %0d, actual %0d",
                      exp_px.column, rsp_pixel_column);
               err_count++;
            end
            if (rsp_last_pixel !== exp_px.last) begin
               $error("last_pixel: expected %0d, actual %0d", exp_px.last, rsp_last_pixel);
               err_count++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phases();
      test_no_idle();
      test_backpressure();

      // drain: all pixels back, then a quiet tail for anything stray
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_count == 0 && pixel_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/tcpr_pkg.sv
sv/tcpr_ram.sv
sv/tcpr_front.sv
sv/tcpr_queue.sv
sv/tcpr_back.sv
sv/text_cell_pixel_renderer.sv
bench/tb.sv
